>>> rtl/cfla_pkg.sv
// ----------------------------------------------------------------------------
// cfla_pkg
// Shared types and constants for the chunked free-list block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cfla_pkg;

  localparam int unsigned MAX_CHUNKS = 8;
  localparam logic [7:0]  MAX_BLOCKS = 8'd255;

  localparam int unsigned SLOT_W     = 8;   // link slots per chunk: 2**SLOT_W
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 16;  // free_chunk, free_block, pad
  localparam int unsigned OUT_DATA_W = 40;  // got_chunk, got_block, byte_offset, pad
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_CHUNK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE       = 1'b1;

  // request kinds
  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

endpackage

`default_nettype wire

>>> rtl/cfla_link_ram.sv
// ----------------------------------------------------------------------------
// cfla_link_ram
// Link store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfla_link_ram #(
  parameter int unsigned AddrW = 11,
  parameter int unsigned DataW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [DataW-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [DataW-1:0] rdata_o
);

  localparam int unsigned Depth = 2 ** AddrW;

  logic [DataW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/chunked_free_list_allocator.sv
// Free goes through S_FREE, allocate from an opened chunk through S_POP, then
// the result is registered. Opening a chunk adds one link write per block in
// S_INIT, then S_RD. Out of memory answers from S_OOM, invalid free from S_FREE.
// One request in flight: a request is taken only in S_IDLE. A result may wait
// in the output register while the next request is taken. Reset clears the
// chunk table and resets the configuration to its defaults at once; the link RAM is not cleared.
// ----------------------------------------------------------------------------
// chunked_free_list_allocator
// Fixed-size block allocator over several chunks, free lists held as links.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_free_list_allocator #(
  parameter int unsigned MaxChunks = cfla_pkg::MAX_CHUNKS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [cfla_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [cfla_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // requests
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  wire logic [cfla_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,  // free_chunk, free_block
  input  wire logic                            s_axis_tuser_i,  // action
  // results
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  output logic [cfla_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,  // got_chunk, got_block, byte_offset
  output logic [cfla_pkg::STATUS_W-1:0]        m_axis_tuser_o   // status
);

  import cfla_pkg::*;

  localparam int unsigned CW    = (MaxChunks > 1) ? $clog2(MaxChunks) : 1;
  localparam int unsigned OW    = $clog2(MaxChunks + 1);
  localparam int unsigned CmpW  = (OW > 3) ? OW : 3;
  localparam int unsigned AddrW = CW + SLOT_W;
  localparam logic [OW-1:0] MaxOpen = OW'(MaxChunks);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_RD,
    S_POP,
    S_FREE,
    S_OOM
  } state_e;

  state_e         state_q;
  logic [7:0]     bpc_q;
  logic [15:0]    bsize_q;
  logic [7:0]     head_q [MaxChunks];
  logic [7:0]     cnt_q  [MaxChunks];
  logic [OW-1:0]  open_q;
  logic [CW-1:0]  cur_q;
  logic           cur_valid_q;
  logic [CW-1:0]  chunk_q;
  logic [2:0]     fchunk_q;
  logic [7:0]     fblock_q;
  logic [7:0]     init_idx_q;
  logic           out_valid_q;
  status_e        out_status_q;
  logic [2:0]     out_chunk_q;
  logic [7:0]     out_block_q;
  logic [23:0]    out_off_q;

  logic [7:0]     n_eff;
  logic           accept;
  logic           out_free;
  logic           out_load;
  logic           use_cur;
  logic           found;
  logic [CW-1:0]  found_idx;
  logic [CW-1:0]  sel_chunk;
  logic [CW-1:0]  fchunk_idx;
  logic           free_ok;
  logic           ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [7:0]     ram_rdata;
  logic [23:0]    offset;

  assign n_eff    = (bpc_q > MAX_BLOCKS) ? MAX_BLOCKS : bpc_q;
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign out_load = out_free && (state_q == S_POP || state_q == S_FREE || state_q == S_OOM);

  assign use_cur = cur_valid_q && (OW'(cur_q) < open_q) && (cnt_q[cur_q] != 8'd0);

  // lowest opened chunk with a free block
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = MaxChunks - 1; i >= 0; i--) begin
      if ((OW'(i) < open_q) && (cnt_q[i] != 8'd0)) begin
        found     = 1'b1;
        found_idx = CW'(i);
      end
    end
  end

  assign sel_chunk  = use_cur ? cur_q : found_idx;
  assign fchunk_idx = CW'(fchunk_q);
  assign free_ok    = (CmpW'(fchunk_q) < CmpW'(open_q)) && (fblock_q < n_eff) &&
                      (cnt_q[fchunk_idx] < n_eff);

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = {chunk_q, head_q[chunk_q]};
    if (state_q == S_IDLE && accept && s_axis_tuser_i == ACT_ALLOC &&
        (use_cur || found)) begin
      ram_re    = 1'b1;
      ram_raddr = {sel_chunk, head_q[sel_chunk]};
    end else if (state_q == S_RD) begin
      ram_re = 1'b1;
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = {chunk_q, init_idx_q};
    ram_wdata = init_idx_q + 8'd1;
    if (state_q == S_INIT) begin
      ram_we = 1'b1;
    end else if (state_q == S_FREE && out_free && free_ok) begin
      ram_we    = 1'b1;
      ram_waddr = {fchunk_idx, fblock_q};
      ram_wdata = head_q[fchunk_idx];
    end
  end

  assign offset = 24'(head_q[chunk_q]) * 24'(bsize_q);

  cfla_link_ram #(
    .AddrW (AddrW),
    .DataW (8)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bpc_q        <= 8'd255;
      bsize_q      <= 16'd16;
      for (int i = 0; i < MaxChunks; i++) begin
        head_q[i] <= 8'd0;
        cnt_q[i]  <= 8'd0;
      end
      open_q       <= '0;
      cur_q        <= '0;
      cur_valid_q  <= 1'b0;
      chunk_q      <= '0;
      fchunk_q     <= '0;
      fblock_q     <= '0;
      init_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_chunk_q  <= '0;
      out_block_q  <= '0;
      out_off_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BLOCKS_PER_CHUNK: bpc_q   <= cfg_wdata_i[7:0];
          CFG_BLOCK_SIZE:       bsize_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            fchunk_q <= s_axis_tdata_i[2:0];
            fblock_q <= s_axis_tdata_i[10:3];
            if (s_axis_tuser_i == ACT_FREE) begin
              state_q <= S_FREE;
            end else if (use_cur || found) begin
              chunk_q     <= sel_chunk;
              cur_q       <= sel_chunk;
              cur_valid_q <= 1'b1;
              state_q     <= S_POP;
            end else if (open_q >= MaxOpen || n_eff == 8'd0) begin
              state_q <= S_OOM;
            end else begin
              chunk_q     <= CW'(open_q);
              cur_q       <= CW'(open_q);
              cur_valid_q <= 1'b1;
              init_idx_q  <= 8'd0;
              state_q     <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (init_idx_q == n_eff - 8'd1) begin
            head_q[chunk_q] <= 8'd0;
            cnt_q[chunk_q]  <= n_eff;
            open_q          <= open_q + OW'(1);
            state_q         <= S_RD;
          end else begin
            init_idx_q <= init_idx_q + 8'd1;
          end
        end
        S_RD: begin
          state_q <= S_POP;
        end
        S_POP: begin
          if (out_free) begin
            head_q[chunk_q] <= ram_rdata;
            cnt_q[chunk_q]  <= cnt_q[chunk_q] - 8'd1;
            out_status_q    <= ST_OK;
            out_chunk_q     <= 3'(chunk_q);
            out_block_q     <= head_q[chunk_q];
            out_off_q       <= offset;
            state_q         <= S_IDLE;
          end
        end
        S_FREE: begin
          if (out_free) begin
            if (free_ok) begin
              head_q[fchunk_idx] <= fblock_q;
              cnt_q[fchunk_idx]  <= cnt_q[fchunk_idx] + 8'd1;
              out_status_q       <= ST_OK;
            end else begin
              out_status_q <= ST_BAD_FREE;
            end
            out_chunk_q <= '0;
            out_block_q <= '0;
            out_off_q   <= '0;
            state_q     <= S_IDLE;
          end
        end
        S_OOM: begin
          if (out_free) begin
            out_status_q <= ST_OOM;
            out_chunk_q  <= '0;
            out_block_q  <= '0;
            out_off_q    <= '0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {5'd0, out_off_q, out_block_q, out_chunk_q};

`ifndef NO_ASSERTIONS
  a_open_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= MaxOpen)
    else $error("more chunks opened than exist");

  a_cur_opened: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_valid_q && state_q == S_IDLE) |-> (OW'(cur_q) < open_q))
    else $error("current chunk not opened");

  a_init_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INIT) |-> (init_idx_q < n_eff && open_q < MaxOpen))
    else $error("link init out of range");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (cnt_q[chunk_q] != 8'd0))
    else $error("pop from empty chunk");
`endif

endmodule

`default_nettype wire
